### rtl/matrix_double_centering_defines.svh
// Assertion macros for the matrix double centering block
`ifndef MATRIX_DOUBLE_CENTERING_DEFINES_SVH
`define MATRIX_DOUBLE_CENTERING_DEFINES_SVH

// implication checked on the next clock edge
`define MDC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mdc: next-cycle check failed");

// implication checked on the same clock edge
`define MDC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mdc: same-cycle check failed");

`endif

### rtl/mdc_pkg.sv
// Types and constants shared by the matrix double centering block
package mdc_pkg;

  localparam int IDX_W  = 6;
  localparam int SUM_D  = 64;
  localparam int CFG_W  = 7;
  localparam int CIX_W  = 2;
  localparam int DATA_W = 32;
  localparam int LINE_W = 38;
  localparam int GRAND_W = 44;
  localparam int DVD_W  = 44;
  localparam int DVS_W  = 14;
  localparam int CNT_W  = 6;
  localparam int ACC_W  = 48;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_LOAD   = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_CENTER = 2'd3;

  localparam logic [CIX_W-1:0] REG_ROWS   = 2'd0;
  localparam logic [CIX_W-1:0] REG_COLS   = 2'd1;
  localparam logic [CIX_W-1:0] REG_DOUBLE = 2'd2;

  localparam logic signed [ACC_W-1:0] SAT_MAX = 48'sd2147483647;
  localparam logic signed [ACC_W-1:0] SAT_MIN = -48'sd2147483648;

endpackage

### rtl/mdc_div.sv
// Bit-serial signed divider, quotient truncated toward zero
module mdc_div
  import mdc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [DVD_W-1:0] dividend_i,
  input  logic        [DVS_W-1:0] divisor_i,
  output logic signed [DVD_W-1:0] quotient_o,
  output logic                    done_o
);

  logic             busy_q, done_q, neg_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVD_W-1:0] quo_q;
  logic [DVS_W-1:0] rem_q, dvs_q;
  logic [DVS_W:0]   rem_sh, diff;
  logic             ge;

  assign rem_sh = {rem_q, quo_q[DVD_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign ge     = !diff[DVS_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DVD_W-1];
      quo_q <= dividend_i[DVD_W-1] ? -dividend_i : dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DVD_W-2:0], ge};
      rem_q <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    end
  end

  assign quotient_o = neg_q ? -quo_q : quo_q;
  assign done_o     = done_q;

endmodule

### rtl/matrix_double_centering.sv
// A load passes through S_LOAD, where in_ready_o is low; a clear leaves in_ready_o high.
// A read or center in range passes through S_RDAT, S_DIV and S_FIN: three serial dividers
// (column, row and grand mean) retire one quotient bit per cycle over 44 bits.
// A read or center out of range goes straight to S_FIN and skips the dividers.
// Reset zeroes all sums (valid bits per row and column) and loads rows = cols = 64.
// The element store holds no reset value.
module matrix_double_centering
  import mdc_pkg::*;
#(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               operation_i,
  input  logic signed [DATA_W-1:0] sample_i,
  input  logic [IDX_W-1:0]         row_i,
  input  logic [IDX_W-1:0]         col_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] value_o,
  output logic                     saturated_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CIX_W-1:0]         cfg_index_i,
  input  logic [CFG_W-1:0]         cfg_data_i
);

  localparam int ELEM_D = MAX_ROWS * MAX_COLS;
  localparam int AW     = (ELEM_D > 1) ? $clog2(ELEM_D) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_RDAT = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [CFG_W-1:0] rows_q, cols_q, nr, nc;
  logic             dbl_q;

  logic signed [DATA_W-1:0]  elem_mem [ELEM_D];
  logic signed [LINE_W-1:0]  row_mem  [SUM_D];
  logic signed [LINE_W-1:0]  col_mem  [SUM_D];
  logic signed [DATA_W-1:0]  elem_rd_q;
  logic signed [LINE_W-1:0]  row_rd_q, col_rd_q;
  logic [SUM_D-1:0]          row_vld_q, col_vld_q;
  logic signed [GRAND_W-1:0] grand_q;

  logic [1:0]               op_q;
  logic [IDX_W-1:0]         r_q, c_q;
  logic signed [DATA_W-1:0] x_q;
  logic                     in_q, oor_q;

  logic             in_xfer, in_range, col_in;
  logic [AW-1:0]    addr;
  logic signed [LINE_W-1:0] row_cur, col_cur;

  logic [2:0] div_done;
  logic signed [DVD_W-1:0] q_cm, q_rm, q_g;
  logic [DVS_W-1:0] nrc;

  logic signed [ACC_W-1:0] center, res;
  logic signed [DATA_W-1:0] res_val;
  logic                     res_sat;

  always_comb begin
    nr = rows_q;
    if (rows_q == '0) nr = CFG_W'(1);
    else if ({25'd0, rows_q} > MAX_ROWS) nr = CFG_W'(MAX_ROWS);
    nc = cols_q;
    if (cols_q == '0) nc = CFG_W'(1);
    else if ({25'd0, cols_q} > MAX_COLS) nc = CFG_W'(MAX_COLS);
  end

  assign nrc      = DVS_W'(nr) * DVS_W'(nc);
  assign in_xfer  = in_valid_i && in_ready_o;
  assign in_range = ({1'b0, row_i} < nr) && ({1'b0, col_i} < nc);
  assign col_in   = {1'b0, col_i} < nc;
  assign addr     = AW'(32'(row_i) * MAX_COLS + 32'(col_i));
  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= CFG_W'(64);
      cols_q <= CFG_W'(64);
      dbl_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ROWS:   rows_q <= cfg_data_i;
        REG_COLS:   cols_q <= cfg_data_i;
        REG_DOUBLE: dbl_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // element store, written on an in-range load transfer, read on every transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer && operation_i == OP_LOAD && in_range) elem_mem[addr] <= sample_i;
    if (in_xfer) elem_rd_q <= elem_mem[addr];
  end

  assign row_cur = row_vld_q[r_q] ? row_rd_q : '0;
  assign col_cur = col_vld_q[c_q] ? col_rd_q : '0;

  // line sums: read every cycle, written back in the cycle after a load transfer
  always_ff @(posedge clk_i) begin
    row_rd_q <= row_mem[row_i];
    col_rd_q <= col_mem[col_i];
    if (state_q == S_LOAD && in_q) begin
      row_mem[r_q] <= row_cur + LINE_W'(x_q);
      col_mem[c_q] <= col_cur + LINE_W'(x_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      col_vld_q <= '0;
      grand_q   <= '0;
    end else if (in_xfer && operation_i == OP_CLEAR) begin
      row_vld_q <= '0;
      col_vld_q <= '0;
      grand_q   <= '0;
    end else if (in_xfer && operation_i == OP_LOAD && in_range) begin
      grand_q <= grand_q + GRAND_W'(sample_i);
    end else if (state_q == S_LOAD && in_q) begin
      row_vld_q[r_q] <= 1'b1;
      col_vld_q[c_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q  <= operation_i;
      r_q   <= row_i;
      c_q   <= col_i;
      x_q   <= sample_i;
      in_q  <= in_range;
      oor_q <= (operation_i == OP_CENTER) ? !col_in : !in_range;
    end
  end

  mdc_div u_div_cm (
    .clk_i, .rst_ni,
    .start_i    (state_q == S_RDAT),
    .dividend_i (DVD_W'(col_cur)),
    .divisor_i  (DVS_W'(nr)),
    .quotient_o (q_cm),
    .done_o     (div_done[0])
  );

  mdc_div u_div_rm (
    .clk_i, .rst_ni,
    .start_i    (state_q == S_RDAT),
    .dividend_i (DVD_W'(row_cur)),
    .divisor_i  (DVS_W'(nc)),
    .quotient_o (q_rm),
    .done_o     (div_done[1])
  );

  mdc_div u_div_g (
    .clk_i, .rst_ni,
    .start_i    (state_q == S_RDAT),
    .dividend_i (DVD_W'(grand_q)),
    .divisor_i  (nrc),
    .quotient_o (q_g),
    .done_o     (div_done[2])
  );

  always_comb begin
    center = ACC_W'(q_cm) - (dbl_q ? ACC_W'(q_g) : '0);
    if (op_q == OP_CENTER) res = center;
    else res = ACC_W'(elem_rd_q) - center - (dbl_q ? ACC_W'(q_rm) : '0);
    res_sat = 1'b0;
    res_val = DATA_W'(res);
    if (oor_q) begin
      res_val = '0;
    end else if (res > SAT_MAX) begin
      res_val = DATA_W'(SAT_MAX);
      res_sat = 1'b1;
    end else if (res < SAT_MIN) begin
      res_val = DATA_W'(SAT_MIN);
      res_sat = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          case (operation_i)
            OP_CLEAR: state_d = S_IDLE;
            OP_LOAD:  state_d = S_LOAD;
            default:  state_d = (((operation_i == OP_CENTER) ? !col_in : !in_range))
                                ? S_FIN : S_RDAT;
          endcase
        end
      end
      S_LOAD: state_d = S_IDLE;
      S_RDAT: state_d = S_DIV;
      S_DIV:  if (&div_done) state_d = S_FIN;
      S_FIN:  if (!out_valid_o || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_FIN && (!out_valid_o || out_ready_i)) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_FIN && (!out_valid_o || out_ready_i)) begin
      value_o     <= res_val;
      saturated_o <= res_sat;
    end
  end

endmodule

### rtl/mdc_chk.sv
// Port-level checks for the matrix double centering block
`include "matrix_double_centering_defines.svh"

module mdc_chk
  import mdc_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic [1:0]               operation_i,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic signed [DATA_W-1:0] value_o,
  input logic                     saturated_o
);

  `MDC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  `MDC_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i,
                   $stable(value_o) && $stable(saturated_o))
  `MDC_ASSERT_NEXT(a_load_busy, in_valid_i && in_ready_o && operation_i == OP_LOAD,
                   !in_ready_o)
  `MDC_ASSERT_NEXT(a_no_early_out, in_valid_i && in_ready_o, !$rose(out_valid_o))

endmodule

bind matrix_double_centering mdc_chk u_mdc_chk (.*);

### tb/testbench.sv
// Self-checking testbench for matrix_double_centering: directed table, then random phases
module testbench;
  import mdc_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     sat;
  } centred_t;

  typedef struct {
    logic [1:0]               op;
    logic signed [DATA_W-1:0] sample;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    bit                       typed;
    logic signed [DATA_W-1:0] exp_value;
    logic                     exp_sat;
  } stim_row_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] operation = OP_CLEAR;
  logic signed [DATA_W-1:0] sample = '0;
  logic [IDX_W-1:0] row = '0;
  logic [IDX_W-1:0] col = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DATA_W-1:0] value;
  logic saturated;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CIX_W-1:0] cfg_index = REG_ROWS;
  logic [CFG_W-1:0] cfg_data = '0;

  // predictor state
  logic signed [DATA_W-1:0]  m_elem [64*64];
  bit                        m_written [64*64];
  logic signed [LINE_W-1:0]  m_row_sum [64];
  logic signed [LINE_W-1:0]  m_col_sum [64];
  logic signed [GRAND_W-1:0] m_grand;
  logic [CFG_W-1:0]          m_rows, m_cols;
  bit                        m_double;

  centred_t pending_results[$];
  centred_t got;
  int  n_mismatch = 0;
  bit  calm = 1'b0;

  matrix_double_centering dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .operation_i(operation), .sample_i(sample), .row_i(row), .col_i(col),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .value_o(value), .saturated_o(saturated),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    n_mismatch++;
  endtask

  function automatic longint used_rows();
    if (m_rows == 0) return 1;
    if (m_rows > 64) return 64;
    return m_rows;
  endfunction

  function automatic longint used_cols();
    if (m_cols == 0) return 1;
    if (m_cols > 64) return 64;
    return m_cols;
  endfunction

  function automatic longint centre_of(input int c);
    longint cm;
    cm = longint'(m_col_sum[c]) / used_rows();
    if (m_double) cm -= longint'(m_grand) / (used_rows() * used_cols());
    return cm;
  endfunction

  function automatic centred_t clip(input longint v);
    centred_t r;
    r.sat = 1'b0;
    if (v > 64'sd2147483647) begin
      v = 64'sd2147483647;
      r.sat = 1'b1;
    end
    if (v < -64'sd2147483648) begin
      v = -64'sd2147483648;
      r.sat = 1'b1;
    end
    r.value = v[DATA_W-1:0];
    return r;
  endfunction

  // advances the predictor by one item; has is set when a result follows
  task automatic centre_predict(input logic [1:0] op, input logic signed [DATA_W-1:0] s,
                                input int r, input int c, output bit has,
                                output centred_t res);
    bit     in_range;
    longint v;
    in_range = (r < used_rows()) && (c < used_cols());
    has = 1'b0;
    res = '0;
    case (op)
      OP_CLEAR: begin
        foreach (m_row_sum[i]) m_row_sum[i] = '0;
        foreach (m_col_sum[i]) m_col_sum[i] = '0;
        m_grand = '0;
      end
      OP_LOAD: begin
        if (in_range) begin
          m_elem[r*64+c] = s;
          m_written[r*64+c] = 1'b1;
          m_row_sum[r] = m_row_sum[r] + s;
          m_col_sum[c] = m_col_sum[c] + s;
          m_grand = m_grand + s;
        end
      end
      OP_READ: begin
        has = 1'b1;
        if (in_range) begin
          v = longint'(m_elem[r*64+c]) - centre_of(c);
          if (m_double) v -= longint'(m_row_sum[r]) / used_cols();
          res = clip(v);
        end
      end
      default: begin
        has = 1'b1;
        if (c < used_cols()) res = clip(centre_of(c));
      end
    endcase
  endtask

  task automatic send_item(input logic [1:0] op, input logic signed [DATA_W-1:0] s,
                           input int r, input int c, input bit typed = 1'b0,
                           input centred_t typed_res = '0);
    bit has;
    centred_t res;
    in_valid  <= 1'b1;
    operation <= op;
    sample    <= s;
    row       <= r[IDX_W-1:0];
    col       <= c[IDX_W-1:0];
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    centre_predict(op, s, r, c, has, res);
    if (has) pending_results.push_back(typed ? typed_res : res);
    if (!calm && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(0, 99) < 33) @(posedge clk_i);
    end
  endtask

  task automatic cfg_write(input logic [CIX_W-1:0] idx, input logic [CFG_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    case (idx)
      REG_ROWS: m_rows = d;
      REG_COLS: m_cols = d;
      default:  m_double = d[0];
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return -32'sd1;
      4: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      default: return $urandom;
    endcase
  endfunction

  task automatic run_phase(input logic [CFG_W-1:0] nr_cfg, input logic [CFG_W-1:0] nc_cfg,
                           input bit dbl, input int n_items);
    int nr, nc, r, c, tries, k, sel;
    int order[$];
    drain();
    cfg_write(REG_ROWS, nr_cfg);
    cfg_write(REG_COLS, nc_cfg);
    cfg_write(REG_DOUBLE, CFG_W'(dbl));
    nr = int'(used_rows());
    nc = int'(used_cols());
    send_item(OP_CLEAR, pick_sample(), 0, 0);
    if (nr * nc <= 64) begin
      for (k = 0; k < nr * nc; k++) order.push_back(k);
      order.shuffle();
      foreach (order[i]) send_item(OP_LOAD, pick_sample(), order[i] / nc, order[i] % nc);
    end else begin
      repeat (64) send_item(OP_LOAD, pick_sample(), $urandom_range(0, nr - 1),
                            $urandom_range(0, nc - 1));
    end
    for (k = 0; k < n_items; k++) begin
      sel = $urandom_range(0, 99);
      r = $urandom_range(0, nr - 1);
      c = $urandom_range(0, nc - 1);
      if (sel < 10) begin
        r = $urandom_range(0, 63);
        c = $urandom_range(0, 63);
        sel = $urandom_range(0, 3);
        if (sel == OP_READ && r < nr && c < nc && !m_written[r*64+c]) sel = OP_CENTER;
        send_item(sel[1:0], $urandom, r, c);
      end else if (sel < 14) begin
        send_item(OP_CLEAR, pick_sample(), r, c);
      end else if (sel < 50) begin
        send_item(OP_LOAD, pick_sample(), r, c);
      end else if (sel < 85) begin
        tries = 0;
        while (!m_written[r*64+c] && tries < 8) begin
          r = $urandom_range(0, nr - 1);
          c = $urandom_range(0, nc - 1);
          tries++;
        end
        send_item(m_written[r*64+c] ? OP_READ : OP_CENTER, pick_sample(), r, c);
      end else begin
        send_item(OP_CENTER, pick_sample(), $urandom_range(0, 63), $urandom_range(0, 63));
      end
    end
  endtask

  stim_row_t directed[$];

  function automatic stim_row_t srow(input logic [1:0] op, input logic signed [DATA_W-1:0] s,
                                     input int r, input int c, input bit typed = 1'b0,
                                     input logic signed [DATA_W-1:0] ev = '0,
                                     input logic es = 1'b0);
    stim_row_t t;
    t.op = op; t.sample = s; t.row = r[IDX_W-1:0]; t.col = c[IDX_W-1:0];
    t.typed = typed; t.exp_value = ev; t.exp_sat = es;
    return t;
  endfunction

  always @(posedge clk_i) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 33);
    if (rst_ni && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result with nothing expected");
      end else begin
        got = pending_results.pop_front();
        if (value !== got.value)
          flag_mismatch($sformatf("value %0d, expected %0d", value, got.value));
        if (saturated !== got.sat)
          flag_mismatch($sformatf("saturated %0b, expected %0b", saturated, got.sat));
      end
    end
  end

  initial begin
    m_rows = 64;
    m_cols = 64;
    m_double = 1'b0;
    m_grand = '0;
    foreach (m_row_sum[i]) m_row_sum[i] = '0;
    foreach (m_col_sum[i]) m_col_sum[i] = '0;
    foreach (m_written[i]) m_written[i] = 1'b0;
    foreach (m_elem[i]) m_elem[i] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // after reset all sums are zero
    send_item(OP_CENTER, '0, 0, 0, 1'b1, '0);
    send_item(OP_CENTER, '0, 63, 63, 1'b1, '0);
    drain();
    cfg_write(REG_ROWS, 2);
    cfg_write(REG_COLS, 3);
    cfg_write(REG_DOUBLE, 1);

    directed.push_back(srow(OP_CLEAR, '0, 0, 0));
    directed.push_back(srow(OP_LOAD, 32'sh8000_0000, 0, 0));
    directed.push_back(srow(OP_LOAD, 32'sh7FFF_FFFF, 0, 1));
    directed.push_back(srow(OP_LOAD, 32'sh7FFF_FFFF, 0, 2));
    directed.push_back(srow(OP_LOAD, -32'sd1, 1, 0));
    directed.push_back(srow(OP_LOAD, '0, 1, 1));
    directed.push_back(srow(OP_LOAD, 32'sh0001_0000, 1, 2));
    directed.push_back(srow(OP_LOAD, 32'sh1234_5678, 2, 0));   // row out of range: ignored
    directed.push_back(srow(OP_LOAD, 32'sh1234_5678, 0, 63));  // col out of range: ignored
    directed.push_back(srow(OP_READ, '0, 0, 0));
    directed.push_back(srow(OP_READ, '0, 0, 1));
    directed.push_back(srow(OP_READ, '0, 1, 2));
    directed.push_back(srow(OP_CENTER, '0, 0, 0));
    directed.push_back(srow(OP_CENTER, '0, 0, 2));
    directed.push_back(srow(OP_READ, '0, 2, 0, 1'b1, '0, 1'b0));
    directed.push_back(srow(OP_READ, '0, 63, 63, 1'b1, '0, 1'b0));
    directed.push_back(srow(OP_CENTER, '0, 0, 3, 1'b1, '0, 1'b0));
    directed.push_back(srow(OP_CENTER, '0, 63, 63, 1'b1, '0, 1'b0));
    // repeated load overwrites and adds again
    directed.push_back(srow(OP_LOAD, 32'sh8000_0000, 0, 0));
    directed.push_back(srow(OP_LOAD, 32'sh7FFF_FFFF, 0, 0));
    directed.push_back(srow(OP_READ, '0, 0, 0));
    // clear keeps the store
    directed.push_back(srow(OP_CLEAR, '0, 0, 0));
    directed.push_back(srow(OP_READ, '0, 0, 0));
    directed.push_back(srow(OP_CENTER, '0, 0, 1, 1'b1, '0, 1'b0));

    foreach (directed[i])
      send_item(directed[i].op, directed[i].sample, directed[i].row, directed[i].col,
                directed[i].typed, {directed[i].exp_value, directed[i].exp_sat});

    run_phase(1, 1, 1'b0, 40);
    run_phase(64, 64, 1'b1, 45);
    run_phase(3, 4, 1'b1, 45);
    calm = 1'b1;
    run_phase(127, 0, 1'b0, 40);
    calm = 1'b0;
    run_phase(5, 2, 1'b0, 40);
    run_phase(8, 8, 1'b1, 45);
    run_phase(0, 7, 1'b1, 40);
    run_phase(64, 1, 1'b0, 40);
    run_phase(2, 64, 1'b1, 45);

    drain();
    if (n_mismatch == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
